// ===== sv/qpv_pkg.sv =====
// Shared types and constants for the quadrature position/velocity counter.
// No dependencies; imported by all qpv modules.

package qpv_pkg;

  localparam int FILTER_BITS = 10;
  localparam int FRAC_BITS   = 8;
  localparam int POS_W       = 32;
  localparam int TIME_W      = 32;
  localparam int MIN_W       = 16;
  localparam int VEL_W       = 40;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 16;
  localparam int SCALE_W     = 20;
  localparam int PROD_W      = POS_W + SCALE_W;
  localparam int DIV_STEPS   = PROD_W + FRAC_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [SCALE_W-1:0] US_PER_S = SCALE_W'(1000000);

  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_MEASURE = 2'd2,
    CMD_SPARE   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_CYCLES   = 2'd0,
    REG_COUNT_ENABLE    = 2'd1,
    REG_MIN_INTERVAL_US = 2'd2,
    REG_SPARE           = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [VEL_W-1:0] quot;
    logic             sat;
    logic             round_up;
  } div_res_t;

endpackage

// ===== sv/qpv_pin_filter.sv =====
// Glitch filter for one encoder pin: a new level is taken after holding
// for thr samples. Depends on qpv_pkg.

module qpv_pin_filter
  import qpv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   raw,
  input  logic [FILTER_BITS-1:0] thr,
  output logic                   level,
  output logic                   level_next
);

  logic [FILTER_BITS-1:0] hold;
  logic [FILTER_BITS-1:0] hold_next;
  logic [FILTER_BITS:0]   hold_inc;

  always_comb begin
    hold_inc   = {1'b0, hold} + {{FILTER_BITS{1'b0}}, 1'b1};
    level_next = level;
    hold_next  = '0;
    if (thr <= FILTER_BITS'(1)) begin
      level_next = raw;
    end else if (raw != level) begin
      if (hold_inc >= {1'b0, thr}) begin
        level_next = raw;
      end else begin
        hold_next = hold_inc[FILTER_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 1'b0;
      hold  <= '0;
    end else if (en) begin
      level <= level_next;
      hold  <= hold_next;
    end
  end

endmodule

// ===== sv/qpv_div.sv =====
// Velocity arithmetic unit: one multiply by 1e6, then a restoring divide
// of the scaled count by dt, one quotient bit per cycle. Depends on qpv_pkg.

module qpv_div
  import qpv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [POS_W-1:0]  mag,
  input  logic [TIME_W-1:0] dt,
  output logic              done,
  output div_res_t          res
);

  logic                 busy;
  logic                 mul_phase;
  logic [STEP_W-1:0]    cnt;
  logic [POS_W-1:0]     mag_r;
  logic [TIME_W-1:0]    dt_r;
  logic [DIV_STEPS-1:0] num_sh;
  logic [TIME_W-1:0]    rem;
  logic [VEL_W-1:0]     quot;
  logic                 sat;
  logic [TIME_W:0]      rem_sh;
  logic                 qbit;
  logic [TIME_W:0]      rem_dbl;
  logic [PROD_W-1:0]    prod;

  always_comb begin
    prod    = PROD_W'(mag_r) * PROD_W'(US_PER_S);
    rem_sh  = {rem, num_sh[DIV_STEPS-1]};
    qbit    = rem_sh >= {1'b0, dt_r};
    rem_dbl = {rem, 1'b0};
  end

  assign done         = busy && !mul_phase && (cnt == '0);
  assign res.quot     = quot;
  assign res.sat      = sat || quot[VEL_W-1];
  assign res.round_up = rem_dbl >= {1'b0, dt_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      mul_phase <= 1'b0;
      cnt       <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      mul_phase <= 1'b1;
      cnt       <= STEP_W'(DIV_STEPS - 1);
    end else if (busy) begin
      if (mul_phase) begin
        mul_phase <= 1'b0;
      end else if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag;
      dt_r  <= dt;
    end else if (busy && mul_phase) begin
      num_sh <= {prod, {FRAC_BITS{1'b0}}};
      rem    <= '0;
      quot   <= '0;
      sat    <= 1'b0;
    end else if (busy) begin
      num_sh <= {num_sh[DIV_STEPS-2:0], 1'b0};
      rem    <= qbit ? TIME_W'(rem_sh - {1'b0, dt_r}) : rem_sh[TIME_W-1:0];
      quot   <= {quot[VEL_W-2:0], qbit};
      sat    <= sat || quot[VEL_W-1];
    end
  end

endmodule

// ===== sv/quadrature_position_velocity_counter_core.sv =====
// Quadrature x4 position counter with velocity measurement.
// Depends on qpv_pkg, qpv_pin_filter and qpv_div.
//
// Each request is one sample of pins A and B with a microsecond timestamp.
// Sample, clear and measure requests without a fresh estimate may follow
// back to back; a request is taken even while the previous result waits at
// the output. A measure request that yields a new velocity holds the input
// through a multiply step, the one-bit-per-cycle restoring divider, a
// finishing state and delivery. The first measure only stores the base and
// returns 0.

module quadrature_position_velocity_counter_core
  import qpv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        cmd,
  input  logic                    pin_a,
  input  logic                    pin_b,
  input  logic [TIME_W-1:0]       now_us,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] position,
  output logic signed [VEL_W-1:0] velocity,
  output logic                    velocity_fresh
);

  logic [FILTER_BITS-1:0] filter_cycles;
  logic                   count_enable;
  logic [MIN_W-1:0]       min_interval_us;

  logic [POS_W-1:0]  position_count;
  logic [POS_W-1:0]  base_count;
  logic [TIME_W-1:0] base_time;
  logic              base_valid;
  logic [VEL_W-1:0]  last_velocity;
  logic              neg;

  logic [POS_W-1:0]  res_position;
  logic [VEL_W-1:0]  res_velocity;
  logic              res_fresh;

  state_t state;
  state_t state_next;

  logic a_level, a_next, b_level, b_next;
  logic accept;
  logic out_free;
  logic a_change, b_change, up;
  logic [POS_W-1:0]  pos_step;
  logic [POS_W-1:0]  pos_next;
  logic [TIME_W-1:0] dt;
  logic              dt_ok;
  logic [POS_W-1:0]  dcount;
  logic [POS_W-1:0]  dmag;
  logic              measure;
  logic              go_calc;
  logic [VEL_W-1:0]  item_vel;
  logic [VEL_W:0]    res_mag;
  logic [VEL_W-1:0]  fin_vel;

  logic load_direct, stash, div_start, fin, deliver;
  logic div_done;
  div_res_t div_res;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  qpv_pin_filter u_filter_a (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .raw        (pin_a),
    .thr        (filter_cycles),
    .level      (a_level),
    .level_next (a_next)
  );

  qpv_pin_filter u_filter_b (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .raw        (pin_b),
    .thr        (filter_cycles),
    .level      (b_level),
    .level_next (b_next)
  );

  qpv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (dmag),
    .dt    (dt),
    .done  (div_done),
    .res   (div_res)
  );

  // decode and position update
  always_comb begin
    a_change = a_next != a_level;
    b_change = b_next != b_level;
    up       = a_change ? (a_next != b_next) : (b_next == a_next);
    pos_step = position_count;
    if (count_enable && (a_change != b_change)) begin
      pos_step = up ? position_count + POS_W'(1) : position_count - POS_W'(1);
    end
    pos_next = (cmd_t'(cmd) == CMD_CLEAR) ? '0 : pos_step;

    measure  = cmd_t'(cmd) == CMD_MEASURE;
    dt       = now_us - base_time;
    dt_ok    = (dt != '0) && (dt >= TIME_W'(min_interval_us));
    dcount   = pos_step - base_count;
    dmag     = dcount[POS_W-1] ? (~dcount + POS_W'(1)) : dcount;
    go_calc  = measure && base_valid && dt_ok;
    item_vel = (measure && !base_valid) ? '0 : last_velocity;
  end

  // rounding, sign and saturation of the divider result
  always_comb begin
    res_mag = {1'b0, div_res.quot} + (VEL_W + 1)'(div_res.round_up);
    if (neg) begin
      if (div_res.sat || res_mag > {1'b0, VEL_MIN}) begin
        fin_vel = VEL_MIN;
      end else begin
        fin_vel = ~res_mag[VEL_W-1:0] + VEL_W'(1);
      end
    end else begin
      if (div_res.sat || res_mag > {1'b0, VEL_MAX}) begin
        fin_vel = VEL_MAX;
      end else begin
        fin_vel = res_mag[VEL_W-1:0];
      end
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && go_calc) begin
          state_next = ST_CALC;
        end else if (in_valid && !out_free) begin
          state_next = ST_HOLD;
        end
      end
      ST_CALC: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall    = 1'b1;
    load_direct = 1'b0;
    stash       = 1'b0;
    div_start   = 1'b0;
    fin         = 1'b0;
    deliver     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        div_start   = in_valid && go_calc;
        load_direct = in_valid && !go_calc && out_free;
        stash       = in_valid && !go_calc && !out_free;
      end
      ST_CALC: begin
      end
      ST_FIN: begin
        fin = 1'b1;
      end
      ST_HOLD: begin
        deliver = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_cycles   <= '0;
      count_enable    <= 1'b1;
      min_interval_us <= MIN_W'(1000);
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_FILTER_CYCLES:   filter_cycles   <= cfg_data[FILTER_BITS-1:0];
        REG_COUNT_ENABLE:    count_enable    <= cfg_data[0];
        REG_MIN_INTERVAL_US: min_interval_us <= cfg_data[MIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      base_count     <= '0;
      base_time      <= '0;
      base_valid     <= 1'b0;
      last_velocity  <= '0;
      neg            <= 1'b0;
    end else begin
      if (accept) begin
        position_count <= pos_next;
        if ((measure && !base_valid) || go_calc) begin
          base_count <= pos_step;
          base_time  <= now_us;
          base_valid <= 1'b1;
        end
        if (go_calc) begin
          neg <= dcount[POS_W-1];
        end
      end
      if (fin) begin
        last_velocity <= fin_vel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stash || div_start) begin
      res_position <= pos_next;
    end
    if (stash) begin
      res_velocity <= item_vel;
      res_fresh    <= 1'b0;
    end else if (fin) begin
      res_velocity <= fin_vel;
      res_fresh    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_direct || deliver) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      position       <= $signed(pos_next);
      velocity       <= $signed(item_vel);
      velocity_fresh <= 1'b0;
    end else if (deliver) begin
      position       <= $signed(res_position);
      velocity       <= $signed(res_velocity);
      velocity_fresh <= res_fresh;
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench for quadrature_position_velocity_counter_core: a directed table, then
// random encoder walks over several register settings, checked by an in-bench tracker.
// Depends on qpv_pkg and the core RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qpv_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [VEL_W-1:0] vel;
    logic             fresh;
  } reading_t;

  typedef struct packed {
    cmd_t              op;
    logic              a;
    logic              b;
    logic [TIME_W-1:0] t;
    logic              typed;
    reading_t          want;
  } vector_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_FILTER_CYCLES;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        cmd = CMD_SAMPLE;
  logic                    pin_a = 1'b0;
  logic                    pin_b = 1'b0;
  logic [TIME_W-1:0]       now_us = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [POS_W-1:0] position;
  logic signed [VEL_W-1:0] velocity;
  logic                    velocity_fresh;

  quadrature_position_velocity_counter_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tracker state and register copies
  logic [FILTER_BITS-1:0] filt_len = '0;
  logic                   count_on = 1'b1;
  logic [MIN_W-1:0]       min_gap = 16'd1000;
  logic                   trk_stable [2] = '{1'b0, 1'b0};
  logic [FILTER_BITS:0]   trk_hold [2] = '{'0, '0};
  logic [POS_W-1:0]       trk_pos = '0;
  logic [POS_W-1:0]       trk_base_pos = '0;
  logic [TIME_W-1:0]      trk_base_t = '0;
  logic                   trk_base_ok = 1'b0;
  logic [VEL_W-1:0]       trk_last_vel = '0;

  reading_t          due_readings [$];
  int                mismatches = 0;
  bit                steady = 1'b0;
  logic [1:0]        gray = 2'd0;
  logic [TIME_W-1:0] stamp = '0;

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 8);
  endfunction

  function automatic vector_t vec(cmd_t op, logic a, logic b, logic [TIME_W-1:0] t,
                                  logic typed, logic [POS_W-1:0] pos,
                                  logic [VEL_W-1:0] vel, logic fresh);
    vector_t v;
    v.op = op;
    v.a = a;
    v.b = b;
    v.t = t;
    v.typed = typed;
    v.want.pos = pos;
    v.want.vel = vel;
    v.want.fresh = fresh;
    return v;
  endfunction

  function automatic void filter_pin(int p, logic raw);
    logic [FILTER_BITS:0] n;
    if (filt_len <= 1) begin
      trk_stable[p] = raw;
      trk_hold[p] = '0;
    end else if (raw == trk_stable[p]) begin
      trk_hold[p] = '0;
    end else begin
      n = trk_hold[p] + 1'b1;
      if (n >= filt_len) begin
        trk_stable[p] = raw;
        trk_hold[p] = '0;
      end else begin
        trk_hold[p] = n;
      end
    end
  endfunction

  // counts per second, Q32.8, rounded half away from zero, saturated
  function automatic logic [VEL_W-1:0] rate_of(logic [POS_W-1:0] dcount,
                                               logic [TIME_W-1:0] dt);
    logic        neg;
    logic [63:0] mag, num, q, r, res, frac, dt64;
    neg = dcount[POS_W-1];
    mag = {32'd0, neg ? (32'd0 - dcount) : dcount};
    dt64 = {32'd0, dt};
    num = mag * 64'd1000000;
    q = num / dt64;
    r = num % dt64;
    if (q >= (64'd1 << (VEL_W - 1 - FRAC_BITS))) begin
      res = (64'd1 << (VEL_W - 1)) + 64'd1;
    end else begin
      frac = ((r << (FRAC_BITS + 1)) + dt64) / (dt64 << 1);
      res = (q << FRAC_BITS) + frac;
    end
    if (neg) begin
      if (res > (64'd1 << (VEL_W - 1))) res = 64'd1 << (VEL_W - 1);
      res = 64'd0 - res;
      return res[VEL_W-1:0];
    end
    if (res > (64'd1 << (VEL_W - 1)) - 64'd1) res = (64'd1 << (VEL_W - 1)) - 64'd1;
    return res[VEL_W-1:0];
  endfunction

  function automatic reading_t track_encoder(cmd_t op, logic a, logic b,
                                             logic [TIME_W-1:0] t);
    reading_t          e;
    logic              oa, ob, ca, cb, up;
    logic [TIME_W-1:0] dt;
    oa = trk_stable[0];
    ob = trk_stable[1];
    filter_pin(0, a);
    filter_pin(1, b);
    ca = trk_stable[0] != oa;
    cb = trk_stable[1] != ob;
    e.vel = trk_last_vel;
    e.fresh = 1'b0;
    if (count_on && ca != cb) begin
      up = ca ? (trk_stable[0] != trk_stable[1]) : (trk_stable[1] == trk_stable[0]);
      trk_pos += up ? 32'd1 : 32'hFFFF_FFFF;
    end
    if (op == CMD_CLEAR) begin
      trk_pos = '0;
    end else if (op == CMD_MEASURE) begin
      if (!trk_base_ok) begin
        trk_base_pos = trk_pos;
        trk_base_t = t;
        trk_base_ok = 1'b1;
        e.vel = '0;
      end else begin
        dt = t - trk_base_t;
        if (dt != 0 && dt >= min_gap) begin
          e.vel = rate_of(trk_pos - trk_base_pos, dt);
          trk_base_pos = trk_pos;
          trk_base_t = t;
          trk_last_vel = e.vel;
          e.fresh = 1'b1;
        end
      end
    end
    e.pos = trk_pos;
    return e;
  endfunction

  task automatic send_request(input vector_t v);
    reading_t got;
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= v.op;
    pin_a <= v.a;
    pin_b <= v.b;
    now_us <= v.t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = track_encoder(v.op, v.a, v.b, v.t);
    due_readings.push_back(v.typed ? v.want : got);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(input logic [FILTER_BITS-1:0] f, input logic en,
                          input logic [MIN_W-1:0] m);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_FILTER_CYCLES;
    cfg_data <= {6'($urandom), f};
    @(posedge clk);
    cfg_index <= REG_COUNT_ENABLE;
    cfg_data <= {15'($urandom), en};
    @(posedge clk);
    cfg_index <= REG_MIN_INTERVAL_US;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    filt_len = f;
    count_on = en;
    min_gap = m;
    @(posedge clk);
  endtask

  // random quadrature walk: each level held long enough to pass the filter, or a glitch
  task automatic wander(input int n);
    int   sent, hold, r;
    cmd_t op;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) gray += 2'd1;
      else if (r < 85) gray += 2'd3;
      else if (r >= 93) gray += 2'd2;
      if (filt_len <= 1) hold = $urandom_range(1, 3);
      else if ($urandom_range(0, 3) == 0) hold = $urandom_range(1, filt_len - 1);
      else hold = $urandom_range(filt_len, filt_len + 4);
      repeat (hold) begin
        if ($urandom_range(0, 99) < 3) stamp = $urandom;
        else stamp += $urandom_range(0, 600);
        r = $urandom_range(0, 99);
        op = r < 6 ? CMD_MEASURE : r < 8 ? CMD_CLEAR : r < 10 ? CMD_SPARE : CMD_SAMPLE;
        send_request(vec(op, gray[1] ^ gray[0], gray[1], stamp, 1'b0, '0, '0, 1'b0));
      end
      sent += hold;
    end
  endtask

  // fast spin measured over one microsecond: large velocity estimates, no idling
  task automatic spin(input bit up);
    steady = 1'b1;
    stamp += 5;
    send_request(vec(CMD_MEASURE, gray[1] ^ gray[0], gray[1], stamp, 1'b0, '0, '0, 1'b0));
    repeat (60) begin
      gray += up ? 2'd1 : 2'd3;
      send_request(vec(CMD_SAMPLE, gray[1] ^ gray[0], gray[1], stamp, 1'b0, '0, '0, 1'b0));
    end
    stamp += 1;
    send_request(vec(CMD_MEASURE, gray[1] ^ gray[0], gray[1], stamp, 1'b0, '0, '0, 1'b0));
    steady = 1'b0;
  endtask

  task automatic report(input string what, input reading_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s exp pos %h vel %h fresh %b, got pos %h vel %h fresh %b", $time,
               what, want.pos, want.vel, want.fresh, position, velocity, velocity_fresh);
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_readings.size() == 0) begin
        report("unexpected result:", '0);
      end else begin
        want = due_readings.pop_front();
        if (position !== want.pos || velocity !== want.vel ||
            velocity_fresh !== want.fresh)
          report("mismatch:", want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= take_break();
  end

  initial begin
    vector_t rows [$];
    rows = '{
      vec(CMD_SAMPLE,  0, 0, 32'd0,    1, 32'd0, 40'd0, 0),
      vec(CMD_SAMPLE,  1, 0, 32'd10,   1, 32'd1, 40'd0, 0),
      vec(CMD_SAMPLE,  1, 1, 32'd20,   1, 32'd2, 40'd0, 0),
      vec(CMD_SAMPLE,  0, 1, 32'd30,   1, 32'd3, 40'd0, 0),
      vec(CMD_SAMPLE,  0, 0, 32'd40,   1, 32'd4, 40'd0, 0),
      vec(CMD_SAMPLE,  0, 1, 32'd50,   1, 32'd3, 40'd0, 0),
      vec(CMD_SAMPLE,  1, 1, 32'd55,   1, 32'd2, 40'd0, 0),
      vec(CMD_SAMPLE,  1, 0, 32'd60,   1, 32'd1, 40'd0, 0),
      vec(CMD_SAMPLE,  0, 0, 32'd65,   1, 32'd0, 40'd0, 0),
      vec(CMD_SAMPLE,  1, 1, 32'd70,   1, 32'd0, 40'd0, 0),
      vec(CMD_SAMPLE,  0, 0, 32'd80,   1, 32'd0, 40'd0, 0),
      vec(CMD_MEASURE, 0, 0, 32'd100,  1, 32'd0, 40'd0, 0),
      vec(CMD_SAMPLE,  1, 0, 32'd200,  1, 32'd1, 40'd0, 0),
      vec(CMD_SPARE,   1, 1, 32'd300,  1, 32'd2, 40'd0, 0),
      vec(CMD_MEASURE, 1, 1, 32'd600,  1, 32'd2, 40'd0, 0),
      vec(CMD_MEASURE, 1, 1, 32'd100,  1, 32'd2, 40'd0, 0),
      vec(CMD_MEASURE, 0, 1, 32'd1100, 1, 32'd3, 40'd768000, 1),
      vec(CMD_CLEAR,   0, 0, 32'd1200, 1, 32'd0, 40'd768000, 0),
      vec(CMD_MEASURE, 0, 0, 32'hFFFF_FFFF, 0, '0, '0, 0),
      vec(CMD_SAMPLE,  1, 0, 32'd0,    0, '0, '0, 0),
      vec(CMD_MEASURE, 1, 0, 32'd999,  0, '0, '0, 0),
      vec(CMD_MEASURE, 1, 1, 32'd2047, 0, '0, '0, 0),
      vec(CMD_SAMPLE,  0, 1, 32'hAAAA_5555, 0, '0, '0, 0),
      vec(CMD_SAMPLE,  0, 0, 32'h5555_AAAA, 0, '0, '0, 0)
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i]);
    stamp = rows[rows.size()-1].t;
    gray = 2'd0;

    set_regs(10'd0, 1'b1, 16'd0);
    wander(50);
    spin(1'b1);
    set_regs(10'd1, 1'b1, 16'd1);
    wander(50);
    spin(1'b0);
    set_regs(10'd3, 1'b1, 16'd500);
    wander(60);
    set_regs(10'd16, 1'b1, 16'd1000);
    wander(100);
    set_regs(10'd2, 1'b0, 16'd65535);
    wander(40);
    set_regs(10'd0, 1'b1, 16'd65535);
    wander(30);
    set_regs(10'd5, 1'b1, 16'd20);
    wander(50);

    settle();
    repeat (70) @(posedge clk);
    if (mismatches == 0 && due_readings.size() == 0)
      $display("quadrature_position_velocity_counter_core test passed");
    else
      $display("quadrature_position_velocity_counter_core test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("quadrature_position_velocity_counter_core test failed");
    $finish;
  end

endmodule
